FILE: hdl/lkvc_pkg.sv
package lkvc_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic capture;   // item accepted: compare keys and latch the plan
        logic commit;    // apply the latched update
        logic load_out;  // fill the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
    } t_dp_status;

endpackage

FILE: hdl/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lkvc_pkg::t_dp_status i_status,
    output lkvc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_blocked;

    // a lookup result cannot be loaded while the previous one still waits
    assign w_blocked = i_status.is_lookup && r_out_valid && !i_out_ready;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        o_cmd.capture  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.commit   = (r_state == ST_UPDATE) && !w_blocked;
        o_cmd.load_out = o_cmd.commit && i_status.is_lookup;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!w_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/lkvc_datapath.sv
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic                       i_mode,
    input  logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [lkvc_pkg::VAL_W-1:0] i_val,
    input  lkvc_pkg::t_dp_cmd          i_cmd,
    output lkvc_pkg::t_dp_status       o_status,
    output logic                       o_hit,
    output logic [lkvc_pkg::VAL_W-1:0] o_read_value
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    // entry storage, one lane per slot
    logic [lkvc_pkg::KEY_W-1:0] r_keys [ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] r_vals [ENTRIES];
    logic [IW-1:0]              r_rank [ENTRIES];
    logic [ENTRIES-1:0]         r_valid;
    logic [CW-1:0]              r_used;
    logic [lkvc_pkg::CAP_W-1:0] r_cap;

    // plan latched at accept
    logic                       r_mode;
    logic                       r_hit;
    logic [lkvc_pkg::KEY_W-1:0] r_in_key;
    logic [lkvc_pkg::VAL_W-1:0] r_in_val;
    logic [IW-1:0]              r_tgt;
    logic [IW-1:0]              r_old;
    logic                       r_touch;
    logic                       r_ins;

    logic                       r_out_hit;
    logic [lkvc_pkg::VAL_W-1:0] r_out_data;

    logic [ENTRIES-1:0] w_match;
    logic               w_hit;
    logic [IW-1:0]      w_hit_idx;
    logic [IW-1:0]      w_free_idx;
    logic [IW-1:0]      w_vict_idx;
    logic [IW-1:0]      w_last_rank;
    logic [CMPW-1:0]    w_cap_ext;
    logic [CMPW-1:0]    w_eff_cap;
    logic               w_free_ok;

    assign w_last_rank = IW'(r_used - CW'(1));
    assign w_cap_ext   = CMPW'(r_cap);

    always_comb begin
        if (w_cap_ext == '0) begin
            w_eff_cap = CMPW'(1);
        end else if (w_cap_ext > CMPW'(ENTRIES)) begin
            w_eff_cap = CMPW'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    assign w_free_ok = CMPW'(r_used) < w_eff_cap;

    // parallel key compare and the lowest-slot priority picks
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        w_vict_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_keys[i] == i_key);
            if (w_match[i]) begin
                w_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
            end
            // ranks of valid entries form 0..used-1, so the oldest holds used-1
            if (r_valid[i] && r_rank[i] == w_last_rank) begin
                w_vict_idx = IW'(i);
            end
        end
        w_hit = |w_match;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_hit    <= w_hit;
            r_in_key <= i_key;
            r_in_val <= i_val;
            if (w_hit) begin
                r_tgt <= w_hit_idx;
                r_old <= r_rank[w_hit_idx];
            end else if (w_free_ok) begin
                r_tgt <= w_free_idx;
                r_old <= w_last_rank;
            end else begin
                r_tgt <= w_vict_idx;
                r_old <= w_last_rank;
            end
        end
        if (i_cmd.load_out) begin
            r_out_hit  <= r_hit;
            r_out_data <= r_hit ? r_vals[r_tgt] : lkvc_pkg::MISS_VALUE;
        end
        if (i_cmd.commit && r_mode) begin
            r_keys[r_tgt] <= r_in_key;
            r_vals[r_tgt] <= r_in_val;
        end
        if (i_cmd.commit && (r_touch || r_ins)) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == r_tgt) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (r_ins || r_rank[i] < r_old)) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            r_cap   <= lkvc_pkg::CAP_RESET;
            r_touch <= 1'b0;
            r_ins   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.capture) begin
                r_touch <= w_hit || (i_mode && !w_free_ok);
                r_ins   <= i_mode && !w_hit && w_free_ok;
            end
            if (i_cmd.commit && r_ins) begin
                r_valid[r_tgt] <= 1'b1;
                r_used         <= r_used + CW'(1);
            end
        end
    end

    assign o_status.is_lookup = !r_mode;
    assign o_hit              = r_out_hit;
    assign o_read_value       = r_out_data;

endmodule

FILE: hdl/lru_key_value_cache_core.sv
// lru key/value cache: fully associative store with least-recently-used replacement
//
// input channel (s_axis): tuser carries mode (0 lookup, 1 store), tdata carries
// key in bits 31:0 and value in bits 63:32. output channel (m_axis): one item per
// lookup, tuser carries hit and tdata the read value (all ones on a miss).
// stores produce no output item. configuration: i_cfg_we writes the capacity
// (i_cfg_wdata); the user must do so only while the block is idle, which the block
// itself does not enforce. zero acts as 1 and values above ENTRIES act as ENTRIES.
//
// timing: the cycle of acceptance compares the key against every slot and picks the
// target slot, the update state then updates the recency ranks and the slot contents;
// the input is ready again after that. a lookup result is loaded into the output
// register when its update commits and is then valid on m_axis. the output register
// decouples the sides: a waiting result does not block a store, a following lookup
// waits in its update cycle until the old result is taken.
// reset (synchronous, active low) clears all valid marks and the use count and sets
// the capacity to 16; slot contents need no clearing, so the block is ready at once.
module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // key [31:0], value [63:32]
    input  logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] i_s_axis_tdata,
    // mode [0]
    input  logic [0:0]                           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // read_value [31:0]
    output logic [lkvc_pkg::VAL_W-1:0]           o_m_axis_tdata,
    // hit [0]
    output logic [0:0]                           o_m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]           i_cfg_wdata
);

    lkvc_pkg::t_dp_cmd    w_cmd;
    lkvc_pkg::t_dp_status w_status;
    logic                 w_hit;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_s_axis_tuser[0]),
        .i_key        (i_s_axis_tdata[lkvc_pkg::KEY_W-1:0]),
        .i_val        (i_s_axis_tdata[lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:lkvc_pkg::KEY_W]),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_hit        (w_hit),
        .o_read_value (o_m_axis_tdata)
    );

    assign o_m_axis_tuser = w_hit;

endmodule
